// File: hdl/sqlrem_pkg.sv
// ----------------------------------------------------------------------------
// sqlrem_pkg
// Shared types and constants for the typed integer remainder pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sqlrem_pkg;

	localparam int DATA_W = 64;
	localparam int HALF_W = 32;
	localparam int KIND_W = 2;
	localparam int STEPS  = DATA_W;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_U32 = 2'd0;
	localparam kind_t KIND_I32 = 2'd1;
	localparam kind_t KIND_I64 = 2'd2;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] dvd;
		logic [DATA_W-1:0] dsr;
		logic              neg;
		kind_t             kind;
		logic              is_null;
	} work_t;

endpackage

`default_nettype wire

// File: hdl/sqlrem_if.sv
// ----------------------------------------------------------------------------
// sqlrem_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqlrem_req_if;
	import sqlrem_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        left_kind;
	logic signed [DATA_W-1:0] left_value;
	logic [KIND_W-1:0]        right_kind;
	logic signed [DATA_W-1:0] right_value;

	modport source (output valid, left_kind, left_value, right_kind, right_value,
		input ready);
	modport sink (input valid, left_kind, left_value, right_kind, right_value,
		output ready);
endinterface

interface sqlrem_res_if;
	import sqlrem_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] remainder_value;
	logic [KIND_W-1:0]        result_kind;
	logic                     result_null;

	modport source (output valid, remainder_value, result_kind, result_null,
		input ready);
	modport sink (input valid, remainder_value, result_kind, result_null,
		output ready);
endinterface

`default_nettype wire

// File: hdl/sqlrem_prep.sv
// ----------------------------------------------------------------------------
// sqlrem_prep
// Entry stage: resolve result kind, widen operands, take magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlrem_prep (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  wire sqlrem_pkg::kind_t left_kind,
	input  wire logic [sqlrem_pkg::DATA_W-1:0] left_value,
	input  wire sqlrem_pkg::kind_t right_kind,
	input  wire logic [sqlrem_pkg::DATA_W-1:0] right_value,
	output logic                  out_valid,
	output sqlrem_pkg::work_t     out_work
);
	import sqlrem_pkg::*;

	function automatic logic [DATA_W-1:0] widen(input kind_t k, input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] r;
		case (k)
			KIND_U32: r = {{(DATA_W-HALF_W){1'b0}}, v[HALF_W-1:0]};
			KIND_I32: r = {{(DATA_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
			default:  r = v;
		endcase
		return r;
	endfunction

	kind_t             lk;
	kind_t             rk;
	kind_t             kind;
	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;
	work_t             work;

	always_comb begin
		lk = (left_kind == KIND_U32 || left_kind == KIND_I32) ? left_kind : KIND_I64;
		rk = (right_kind == KIND_U32 || right_kind == KIND_I32) ? right_kind : KIND_I64;
		if (lk == KIND_U32 && rk == KIND_U32) begin
			kind = KIND_U32;
		end else if (lk == KIND_I32 && rk == KIND_I32) begin
			kind = KIND_I32;
		end else begin
			kind = KIND_I64;
		end
		a = widen(lk, left_value);
		b = widen(rk, right_value);
		work.rem     = '0;
		work.neg     = a[DATA_W-1];
		work.dvd     = a[DATA_W-1] ? (~a + 1'b1) : a;
		work.dsr     = b[DATA_W-1] ? (~b + 1'b1) : b;
		work.kind    = kind;
		work.is_null = (b == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_work <= work;
		end
	end

endmodule

`default_nettype wire

// File: hdl/sqlrem_step.sv
// ----------------------------------------------------------------------------
// sqlrem_step
// One restoring division step: shift in a dividend bit, subtract if it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlrem_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire sqlrem_pkg::work_t in_work,
	output logic                   out_valid,
	output sqlrem_pkg::work_t      out_work
);
	import sqlrem_pkg::*;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   dsr_x;
	logic [DATA_W:0]   diff;
	logic              fits;
	work_t             work;

	always_comb begin
		trial = {in_work.rem, in_work.dvd[DATA_W-1]};
		dsr_x = {1'b0, in_work.dsr};
		fits  = (trial >= dsr_x);
		diff  = trial - dsr_x;
		work      = in_work;
		work.rem  = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
		work.dvd  = {in_work.dvd[DATA_W-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_work <= work;
		end
	end

endmodule

`default_nettype wire

// File: hdl/sqlrem_out.sv
// ----------------------------------------------------------------------------
// sqlrem_out
// Sign fix, null masking, output register and skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlrem_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire sqlrem_pkg::work_t in_work,
	output logic                   adv,
	sqlrem_res_if.source           res
);
	import sqlrem_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		kind_t             kind;
		logic              is_null;
	} result_t;

	result_t fin;
	result_t out_q;
	result_t skid_q;
	logic    out_v_q;
	logic    skid_v_q;
	logic    push;
	logic    load_out;
	logic    load_skid;

	always_comb begin
		if (in_work.is_null) begin
			fin.value = '0;
		end else if (in_work.neg) begin
			fin.value = ~in_work.rem + 1'b1;
		end else begin
			fin.value = in_work.rem;
		end
		fin.kind    = in_work.kind;
		fin.is_null = in_work.is_null;
		adv         = !skid_v_q;
		push        = adv && in_valid;
		load_out    = push && (!out_v_q || res.ready);
		load_skid   = push && out_v_q && !res.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (res.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (load_skid) begin
			skid_v_q <= 1'b1;
		end else if (res.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q && res.ready) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= fin;
		end
		if (load_skid) begin
			skid_q <= fin;
		end
	end

	assign res.valid           = out_v_q;
	assign res.remainder_value = out_q.value;
	assign res.result_kind     = out_q.kind;
	assign res.result_null     = out_q.is_null;

endmodule

`default_nettype wire

// File: hdl/sql_integer_remainder_top.sv
// ----------------------------------------------------------------------------
// sql_integer_remainder_top
// Truncated remainder of two typed integers (uint32, int32, int64).
// ----------------------------------------------------------------------------
// One request enters per cycle unless the pipeline stalls, and passes one
// entry stage that widens the operands and takes magnitudes, 64 stages of a
// restoring division that each shift in one dividend bit and do one 65-bit
// compare and subtract, and an output register after the sign fix. A skid
// register behind the output keeps the pipeline taking requests while a
// result waits; it stalls only when both output and skid hold results.
// Two uint32 operands give uint32, two int32 give int32, any other mix gives
// int64; a zero divisor flags a null result with value 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_integer_remainder_top (
	input wire logic     clk,
	input wire logic     arst_n,
	sqlrem_req_if.sink   req,
	sqlrem_res_if.source res
);
	import sqlrem_pkg::*;

	logic  adv;
	logic  stage_v_s [0:STEPS];
	work_t stage_w_s [0:STEPS];

	assign req.ready = adv;

	sqlrem_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (req.valid),
		.left_kind   (req.left_kind),
		.left_value  (req.left_value),
		.right_kind  (req.right_kind),
		.right_value (req.right_value),
		.out_valid   (stage_v_s[0]),
		.out_work    (stage_w_s[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		sqlrem_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (stage_v_s[i]),
			.in_work   (stage_w_s[i]),
			.out_valid (stage_v_s[i+1]),
			.out_work  (stage_w_s[i+1])
		);
	end

	sqlrem_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stage_v_s[STEPS]),
		.in_work  (stage_w_s[STEPS]),
		.adv      (adv),
		.res      (res)
	);

endmodule

`default_nettype wire

// File: hdl/sqlrem_check.sv
// ----------------------------------------------------------------------------
// sqlrem_check
// Port-level checks on the result channel of the remainder block.
// ----------------------------------------------------------------------------
`default_nettype none

module sqlrem_check (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            res_valid,
	input wire logic                            res_ready,
	input wire logic [sqlrem_pkg::DATA_W-1:0]   res_value,
	input wire sqlrem_pkg::kind_t               res_kind,
	input wire logic                            res_null
);
	import sqlrem_pkg::*;

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_null |-> res_value == '0)
		else $error("null result with nonzero value");

	a_u32_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_U32 |-> res_value[DATA_W-1:HALF_W] == '0)
		else $error("uint32 result out of range");

	a_i32_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_I32 |->
			(res_value[DATA_W-1:HALF_W-1] == '0 || res_value[DATA_W-1:HALF_W-1] == '1))
		else $error("int32 result not sign-extended");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=>
			res_valid && $stable(res_value) && $stable(res_kind) && $stable(res_null))
		else $error("stalled result changed");

endmodule

bind sql_integer_remainder_top sqlrem_check u_sqlrem_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_value (res.remainder_value),
	.res_kind  (res.result_kind),
	.res_null  (res.result_null)
);

`default_nettype wire
